// File: rtl/mse_pkg.sv
// Mailbox sync endpoint package: payload structs, operation and message codes.
`default_nettype none
package mse_pkg;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] local_value;
    logic [7:0]  rx_command;
    logic [31:0] rx_value;
  } mse_cmd_t;

  typedef struct packed {
    logic        pending;
    logic        tx_valid;
    logic [1:0]  tx_command;
    logic [31:0] tx_value;
    logic [1:0]  handle_status;
    logic        notify_valid;
    logic        notify_changed;
    logic [31:0] current_value;
  } mse_rsp_t;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_BUS_RESET = 3'd2;
  localparam logic [2:0] OP_POLL      = 3'd3;
  localparam logic [2:0] OP_RECEIVE   = 3'd4;

  localparam logic [7:0] RX_SEND_VALUE  = 8'd0;
  localparam logic [7:0] RX_ACK_VALUE   = 8'd1;
  localparam logic [7:0] RX_SEND_CHANGE = 8'd2;

  localparam logic [1:0] TX_SEND_VALUE  = 2'd0;
  localparam logic [1:0] TX_ACK_VALUE   = 2'd1;
  localparam logic [1:0] TX_SEND_CHANGE = 2'd2;

  localparam logic [1:0] ST_CONSUMED = 2'd0;
  localparam logic [1:0] ST_REPLIED  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;

  localparam logic CFG_IS_MASTER      = 1'b0;
  localparam logic CFG_RETRY_INTERVAL = 1'b1;

endpackage
`default_nettype wire

// File: rtl/mailbox_sync_endpoint.sv
// Mailbox sync endpoint top: command register, core, result register.
//
//   channel  signals                       dir  payload
//   cmd      cmd_valid / cmd_stall         in   mse_cmd_t word
//   rsp      rsp_valid / rsp_stall         out  mse_rsp_t word
//   cfg      cfg_valid / cfg_ready         in   cfg_index, cfg_data
//
// One word per cycle sustained while rsp is not stalled; from cmd accept to rsp
// valid a word passes the command register, then the state update into the result register.
// Reset: is_master 0, retry_interval 100, value 0, in sync, timer ready.
// A stalled rsp holds its word; the command register keeps taking one more
// word, then cmd_stall rises. cfg_ready is always high.
`default_nettype none
module mailbox_sync_endpoint
  import mse_pkg::*;
#(
  parameter int unsigned VALUE_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire mse_cmd_t    cmd,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output mse_rsp_t         rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  mse_cmd_t cmd_q;
  logic     cmd_q_valid;
  logic     advance;
  mse_rsp_t result;

  assign cfg_ready = 1'b1;
  assign advance   = cmd_q_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = cmd_q_valid && !advance;

  mse_core #(
    .VALUE_BYTES(VALUE_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_sel  (cfg_index),
    .cfg_wdata(cfg_data),
    .step     (advance),
    .word     (cmd_q),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (!cmd_stall) cmd_q_valid <= cmd_valid;
      if (advance) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
    if (!cmd_stall && cmd_valid) cmd_q <= cmd;
    if (advance) rsp <= result;
  end

endmodule
`default_nettype wire

// File: rtl/mse_core.sv
// Mailbox sync endpoint core: config, sync state and single-pass word update.
`default_nettype none
module mse_core
  import mse_pkg::*;
#(
  parameter int unsigned VALUE_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_sel,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        step,
  input  wire mse_cmd_t    word,
  output mse_rsp_t         result
);

  localparam int unsigned VW = ((VALUE_BYTES > 4) ? 4 : VALUE_BYTES) * 8;

  logic           is_master;
  logic [15:0]    retry_interval;

  logic [VW-1:0]  stored_value, stored_value_next;
  logic           in_sync, in_sync_next;
  logic           local_change, local_change_next;
  logic           change_flag, change_flag_next;
  logic [15:0]    retry_count, retry_count_next;

  logic [VW-1:0]  lval, rval;
  logic           tx_valid, nvalid, nchanged;
  logic [1:0]     tx_cmd, status;
  logic [VW-1:0]  tx_val;
  logic           pending_now;

  assign lval        = word.local_value[VW-1:0];
  assign rval        = word.rx_value[VW-1:0];
  assign pending_now = !in_sync && (retry_count == '0);

  always_comb begin
    stored_value_next = stored_value;
    in_sync_next      = in_sync;
    local_change_next = local_change;
    change_flag_next  = change_flag;
    retry_count_next  = retry_count;
    tx_valid          = 1'b0;
    tx_cmd            = TX_SEND_VALUE;
    tx_val            = '0;
    status            = ST_CONSUMED;
    nvalid            = 1'b0;
    nchanged          = 1'b0;
    unique case (word.operation)
      OP_TICK: begin
        if (retry_count != '0) retry_count_next = retry_count - 16'd1;
      end
      OP_WRITE: begin
        stored_value_next = lval;
        in_sync_next      = 1'b0;
        local_change_next = 1'b1;
        change_flag_next  = 1'b1;
        retry_count_next  = '0;
      end
      OP_BUS_RESET: begin
        retry_count_next = '0;
        in_sync_next     = !local_change;
        change_flag_next = 1'b0;
      end
      OP_POLL: begin
        if (pending_now) begin
          tx_valid         = 1'b1;
          tx_cmd           = (change_flag && local_change) ? TX_SEND_CHANGE : TX_SEND_VALUE;
          tx_val           = stored_value;
          retry_count_next = retry_interval;
        end
      end
      OP_RECEIVE: begin
        if (word.rx_command == RX_SEND_VALUE || word.rx_command == RX_SEND_CHANGE) begin
          status   = ST_REPLIED;
          tx_valid = 1'b1;
          tx_cmd   = TX_ACK_VALUE;
          tx_val   = rval;
          if (local_change && is_master) begin
            in_sync_next = 1'b0;
          end else begin
            stored_value_next = rval;
            in_sync_next      = 1'b1;
            local_change_next = 1'b0;
            nvalid            = 1'b1;
            nchanged          = change_flag || (word.rx_command == RX_SEND_CHANGE);
            change_flag_next  = 1'b0;
          end
        end else if (word.rx_command == RX_ACK_VALUE) begin
          if (rval == stored_value) in_sync_next = 1'b1;
          change_flag_next = 1'b0;
        end else begin
          status = ST_UNKNOWN;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result                = '0;
    result.pending        = !in_sync_next && (retry_count_next == '0);
    result.tx_valid       = tx_valid;
    result.tx_command     = tx_cmd;
    result.tx_value[VW-1:0]      = tx_val;
    result.handle_status  = status;
    result.notify_valid   = nvalid;
    result.notify_changed = nchanged;
    result.current_value[VW-1:0] = stored_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_master      <= 1'b0;
      retry_interval <= 16'd100;
      stored_value   <= '0;
      in_sync        <= 1'b1;
      local_change   <= 1'b0;
      change_flag    <= 1'b0;
      retry_count    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_sel)
          CFG_IS_MASTER:      is_master      <= cfg_wdata[0];
          CFG_RETRY_INTERVAL: retry_interval <= cfg_wdata;
          default: ;
        endcase
      end
      if (step) begin
        stored_value <= stored_value_next;
        in_sync      <= in_sync_next;
        local_change <= local_change_next;
        change_flag  <= change_flag_next;
        retry_count  <= retry_count_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/mailbox_sync_endpoint_test.sv
// Self-checking testbench for the mailbox sync endpoint: directed and random traffic.
`timescale 1ns / 1ps
module mailbox_sync_endpoint_test
  import mse_pkg::*;
();

  localparam int unsigned ValueBytes = 4;
  localparam logic [31:0] ValueMask = (ValueBytes >= 4) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << (8 * ValueBytes)) - 64'd1);
  localparam int QuietLimit = 5000;
  localparam int WordsPerPhase = 190;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  mse_cmd_t    cmd = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  mse_rsp_t    rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // predicted endpoint state and registers
  logic [31:0] mb_value = '0;
  logic        mb_in_sync = 1'b1;
  logic        mb_local_change = 1'b0;
  logic        mb_change_flag = 1'b0;
  logic [15:0] mb_retry = '0;
  logic        cfg_master = 1'b0;
  logic [15:0] cfg_retry = 16'd100;

  mse_rsp_t awaited_rsp_q[$];
  bit       failed = 1'b0;
  bit       cmd_idle_on = 1'b1;
  bit       rsp_idle_on = 1'b1;
  int       stall_left = 0;
  int       quiet_cycles = 0;

  mailbox_sync_endpoint #(.VALUE_BYTES(ValueBytes)) dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic mse_rsp_t predict_mailbox(input mse_cmd_t c);
    mse_rsp_t    r;
    logic [31:0] lval;
    logic [31:0] rval;
    r = '0;
    lval = c.local_value & ValueMask;
    rval = c.rx_value & ValueMask;
    case (c.operation)
      OP_TICK: begin
        if (mb_retry != 16'd0) mb_retry = mb_retry - 16'd1;
      end
      OP_WRITE: begin
        mb_value = lval;
        mb_in_sync = 1'b0;
        mb_local_change = 1'b1;
        mb_change_flag = 1'b1;
        mb_retry = '0;
      end
      OP_BUS_RESET: begin
        mb_retry = '0;
        mb_in_sync = !mb_local_change;
        mb_change_flag = 1'b0;
      end
      OP_POLL: begin
        if (!mb_in_sync && mb_retry == 16'd0) begin
          r.tx_valid = 1'b1;
          r.tx_command = (mb_change_flag && mb_local_change) ? TX_SEND_CHANGE : TX_SEND_VALUE;
          r.tx_value = mb_value;
          mb_retry = cfg_retry;
        end
      end
      OP_RECEIVE: begin
        if (c.rx_command == RX_SEND_VALUE || c.rx_command == RX_SEND_CHANGE) begin
          r.handle_status = ST_REPLIED;
          r.tx_valid = 1'b1;
          r.tx_command = TX_ACK_VALUE;
          r.tx_value = rval;
          if (mb_local_change && cfg_master) begin
            mb_in_sync = 1'b0;
          end else begin
            mb_value = rval;
            mb_in_sync = 1'b1;
            mb_local_change = 1'b0;
            if (c.rx_command == RX_SEND_CHANGE) mb_change_flag = 1'b1;
            r.notify_valid = 1'b1;
            r.notify_changed = mb_change_flag;
            mb_change_flag = 1'b0;
          end
        end else if (c.rx_command == RX_ACK_VALUE) begin
          if (rval == mb_value) mb_in_sync = 1'b1;
          mb_change_flag = 1'b0;
          r.handle_status = ST_CONSUMED;
        end else begin
          r.handle_status = ST_UNKNOWN;
        end
      end
      default: ;
    endcase
    r.pending = !mb_in_sync && mb_retry == 16'd0;
    r.current_value = mb_value;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // scoreboard, predictor and register shadow, all on the rising edge
  always @(posedge clk) begin
    mse_rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp_q.size() == 0) begin
          $display("%0t: result word %h with none expected", $time, rsp);
          failed = 1'b1;
        end else begin
          want = awaited_rsp_q.pop_front();
          check_field("pending", want.pending, rsp.pending);
          check_field("tx_valid", want.tx_valid, rsp.tx_valid);
          check_field("tx_command", want.tx_command, rsp.tx_command);
          check_field("tx_value", want.tx_value, rsp.tx_value);
          check_field("handle_status", want.handle_status, rsp.handle_status);
          check_field("notify_valid", want.notify_valid, rsp.notify_valid);
          check_field("notify_changed", want.notify_changed, rsp.notify_changed);
          check_field("current_value", want.current_value, rsp.current_value);
        end
      end
      if (cmd_valid && !cmd_stall) awaited_rsp_q.push_back(predict_mailbox(cmd));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IS_MASTER:      cfg_master = cfg_data[0];
          CFG_RETRY_INTERVAL: cfg_retry = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result backpressure: mostly short stalls, now and then a long one
  always @(negedge clk) begin
    int pick;
    pick = $urandom_range(99);
    if (!rsp_idle_on) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (pick < 3) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(40, 15);
    end else if (pick < 25) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(2, 0);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (!cmd_idle_on || p < 70) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [31:0] random_value();
    int p;
    p = $urandom_range(9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return $urandom;
  endfunction

  function automatic mse_cmd_t word_of(input logic [2:0] op, input logic [31:0] lval,
                                       input logic [7:0] rcmd, input logic [31:0] rval);
    mse_cmd_t w;
    w.operation = op;
    w.local_value = lval;
    w.rx_command = rcmd;
    w.rx_value = rval;
    return w;
  endfunction

  // mostly write/poll/receive exchanges with random content, plus ticks, bus resets and noise
  function automatic mse_cmd_t random_word();
    mse_cmd_t w;
    int       p;
    w = word_of(OP_TICK, random_value(), 8'($urandom_range(255)), random_value());
    p = $urandom_range(99);
    if (p < 25) w.operation = OP_TICK;
    else if (p < 40) w.operation = OP_WRITE;
    else if (p < 45) w.operation = OP_BUS_RESET;
    else if (p < 68) w.operation = OP_POLL;
    else if (p < 97) w.operation = OP_RECEIVE;
    else w.operation = 3'($urandom_range(7, 5));
    if (w.operation == OP_RECEIVE) begin
      p = $urandom_range(99);
      if (p < 30) w.rx_command = RX_SEND_VALUE;
      else if (p < 55) w.rx_command = RX_SEND_CHANGE;
      else if (p < 92) begin
        w.rx_command = RX_ACK_VALUE;
        if ($urandom_range(99) < 65) w.rx_value = mb_value;
      end else w.rx_command = 8'($urandom_range(255, 3));
    end
    return w;
  endfunction

  task automatic drive_word(input mse_cmd_t w);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic settle_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // slave role with reset settings: idle polls, junk, a full exchange, accepts
  task automatic test_slave_exchange();
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_TICK, '1, '1, '1));
    drive_word(word_of(3'd5, '1, '1, '1));
    drive_word(word_of(3'd7, '0, '0, '0));
    drive_word(word_of(OP_RECEIVE, '0, 8'd3, 32'h0000_0042));
    drive_word(word_of(OP_RECEIVE, '0, 8'd255, '1));
    drive_word(word_of(OP_RECEIVE, '0, RX_ACK_VALUE, '0));
    drive_word(word_of(OP_WRITE, '1, '0, '0));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_TICK, '0, '0, '0));
    drive_word(word_of(OP_RECEIVE, '0, RX_ACK_VALUE, '0));
    drive_word(word_of(OP_BUS_RESET, '0, '0, '0));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_RECEIVE, '0, RX_ACK_VALUE, '1));
    drive_word(word_of(OP_RECEIVE, '0, RX_SEND_VALUE, 32'h1234_5678));
    drive_word(word_of(OP_WRITE, 32'hA5A5_A5A5, '0, '0));
    drive_word(word_of(OP_RECEIVE, '0, RX_SEND_VALUE, '0));
    drive_word(word_of(OP_RECEIVE, '0, RX_SEND_CHANGE, '1));
    drive_word(word_of(OP_BUS_RESET, '0, '0, '0));
    drive_word(word_of(3'd6, '0, '0, '0));
  endtask

  // master keeps its own change against incoming sends, then as slave accepts a send
  task automatic test_master_contention();
    settle_idle();
    write_reg(CFG_IS_MASTER, 16'hFFFF);
    write_reg(CFG_RETRY_INTERVAL, 16'h0000);
    drive_word(word_of(OP_WRITE, 32'h0000_0001, '0, '0));
    drive_word(word_of(OP_RECEIVE, '0, RX_SEND_VALUE, 32'hDEAD_BEEF));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_RECEIVE, '0, RX_ACK_VALUE, 32'hDEAD_BEEF));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_RECEIVE, '0, RX_ACK_VALUE, 32'h0000_0001));
    drive_word(word_of(OP_RECEIVE, '0, RX_SEND_CHANGE, 32'h0000_0007));
    settle_idle();
    write_reg(CFG_IS_MASTER, 16'hFFFE);
    drive_word(word_of(OP_RECEIVE, '0, RX_SEND_VALUE, 32'h0000_0007));
  endtask

  // resend timing at a short interval and at the largest one
  task automatic test_retry_timer();
    settle_idle();
    write_reg(CFG_RETRY_INTERVAL, 16'd2);
    drive_word(word_of(OP_WRITE, 32'h0000_0055, '0, '0));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_TICK, '0, '0, '0));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_TICK, '0, '0, '0));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    settle_idle();
    write_reg(CFG_RETRY_INTERVAL, 16'hFFFF);
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_TICK, '0, '0, '0));
    drive_word(word_of(OP_POLL, '0, '0, '0));
    drive_word(word_of(OP_BUS_RESET, '0, '0, '0));
    drive_word(word_of(OP_POLL, '0, '0, '0));
  endtask

  task automatic run_phase(input logic master, input logic [15:0] retry,
                           input bit cmd_idle, input bit rsp_idle);
    settle_idle();
    write_reg(CFG_IS_MASTER, {15'($urandom), master});
    write_reg(CFG_RETRY_INTERVAL, retry);
    cmd_idle_on = cmd_idle;
    rsp_idle_on = rsp_idle;
    for (int n = 0; n < WordsPerPhase; n++) begin
      if ($urandom_range(79) == 0) settle_idle();
      drive_word(random_word());
    end
  endtask

  task automatic test_random_traffic();
    run_phase(1'b0, 16'd100, 1'b1, 1'b1);
    run_phase(1'b1, 16'd0, 1'b1, 1'b1);
    run_phase(1'b0, 16'd1, 1'b0, 1'b0);
    run_phase(1'b1, 16'd3, 1'b1, 1'b0);
    run_phase(1'b0, 16'hFFFF, 1'b0, 1'b1);
    run_phase(1'b1, 16'd2, 1'b1, 1'b1);
    run_phase(1'b0, 16'd5, 1'b1, 1'b1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_slave_exchange();
    test_master_contention();
    test_retry_timer();
    test_random_traffic();
    settle_idle();
    repeat (4) @(posedge clk);
    if (!failed && awaited_rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
